/* hdl/gpcs_pkg.sv */
// Shared types, constants and elaboration-time table functions for the
// gaussian puff concentration block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpcs_pkg;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam int POS_W    = 24;
    localparam int SPREAD_W = 24;
    localparam int PEAK_W   = 40;
    localparam int SUM_W    = 48;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // iterative divider sizes: 64-bit quotient, divisor up to sigma^3
    localparam int QUO_W  = 64;
    localparam int DEN_W  = 72;
    localparam int ITER_W = 7;
    localparam logic [ITER_W-1:0] ITERS_R = 7'd16;
    localparam logic [ITER_W-1:0] ITERS_T = 7'd64;

    // exp value width (Q30, up to 1.0)
    localparam int E_W = 31;
    localparam int COARSE_SIZE = 13;

    // one stored filament
    typedef struct packed {
        logic                       grp;
        logic                       vld;
        logic [SPREAD_W-1:0]        spread;
        logic signed [POS_W-1:0]    z;
        logic signed [POS_W-1:0]    y;
        logic signed [POS_W-1:0]    x;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // divider control
    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } div_ctl_t;

    // exp(-x), x in Q30 within [0,1], truncated alternating series
    function automatic logic [63:0] exp_series(input logic [63:0] x, input int terms);
        longint     acc;
        logic [63:0] t;
        acc = longint'(64'd1 << 30);
        t   = 64'd1 << 30;
        for (int n = 1; n <= terms; n++) begin
            t = ((t * x) >> 30) / 64'(n);
            if ((n % 2) == 1)
                acc = acc - longint'(t);
            else
                acc = acc + longint'(t);
        end
        if (acc < 0)
            acc = 0;
        return 64'(acc);
    endfunction

    // fine table entry: exp(-i / 2^b)
    function automatic logic [E_W-1:0] fine_val(input int i, input int b);
        logic [63:0] v;
        v = exp_series(64'(i) << (30 - b), 16);
        return v[E_W-1:0];
    endfunction

    // coarse table entry: exp(-n) from rounded products of exp(-1)
    function automatic logic [E_W-1:0] coarse_val(input int n);
        logic [63:0] e1;
        logic [63:0] c;
        e1 = exp_series(64'd1 << 30, 20);
        c  = 64'd1 << 30;
        for (int k = 1; k <= n; k++) begin
            c = (c * e1 + (64'd1 << 29)) >> 30;
        end
        return c[E_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/gpcs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gpcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/gpcs_div.sv */
// Restoring divider, one quotient bit per cycle, with preset remainder.
// Depends on gpcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpcs_div
    import gpcs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_ctl_t         ctl,
    input  wire logic [DEN_W-1:0] rem_init,
    input  wire logic [QUO_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo,
    output logic                  done
);

    logic [DEN_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // one trial subtract per step
    assign trial = {rem_reg, num_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= rem_init;
            num_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_reg <= {num_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* hdl/gpcs_exp.sv */
// Two-stage exp(-d^2/(2 sigma^2)) lookup: coarse and fine tables, then product.
// Depends on gpcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpcs_exp
    import gpcs_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 8
) (
    input  wire logic           clk,
    input  wire logic [15:0]    ratio,
    output logic      [E_W-1:0] e
);

    localparam int FINE_SIZE = 1 << EXP_TABLE_BITS;
    localparam int U_W       = EXP_TABLE_BITS + 4;

    logic [E_W-1:0] fine_rom   [FINE_SIZE];
    logic [E_W-1:0] coarse_rom [COARSE_SIZE];

    genvar gi;
    generate
        for (gi = 0; gi < FINE_SIZE; gi++)
        begin : g_fine
            assign fine_rom[gi] = fine_val(gi, EXP_TABLE_BITS);
        end
        for (gi = 0; gi < COARSE_SIZE; gi++)
        begin : g_coarse
            assign coarse_rom[gi] = coarse_val(gi);
        end
    endgenerate

    // u = 25*r*2^B / 2^17
    logic [20:0]                   prod25;
    logic [20+EXP_TABLE_BITS:0]    ushift;
    logic [U_W-1:0]                u;
    logic [3:0]                    n_raw;
    logic [3:0]                    n_idx;
    logic [EXP_TABLE_BITS-1:0]     f_idx;

    assign prod25 = {1'b0, ratio, 4'b0} + {2'b0, ratio, 3'b0} + {5'b0, ratio};
    assign ushift = {prod25, {EXP_TABLE_BITS{1'b0}}};
    assign u      = ushift[20+EXP_TABLE_BITS:17];
    assign n_raw  = u[U_W-1:EXP_TABLE_BITS];
    assign n_idx  = (n_raw > 4'(COARSE_SIZE - 1)) ? 4'(COARSE_SIZE - 1) : n_raw;
    assign f_idx  = u[EXP_TABLE_BITS-1:0];

    // stage 1: table reads
    logic [E_W-1:0] coarse_reg;
    logic [E_W-1:0] fine_reg;
    // stage 2: rounded Q30 product
    logic [61:0]    prod;
    logic [E_W-1:0] e_reg;

    assign prod = 62'(coarse_reg) * 62'(fine_reg) + (62'd1 << 29);

    always_ff @(posedge clk)
    begin
        coarse_reg <= coarse_rom[n_idx];
        fine_reg   <= fine_rom[f_idx];
        e_reg      <= prod[60:30];
    end

    assign e = e_reg;

endmodule

`default_nettype wire

/* hdl/gaussian_puff_concentration_sum.sv */
// Top level: filament table in RAM, query walk sequencer and term datapath.
// Depends on gpcs_pkg, gpcs_ram, gpcs_div, gpcs_exp.
//
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+------------------------
//  command   | command pos_x pos_y pos_z spread entry_valid    | start & !busy
//            | gas_group                                       |
//  result    | conc_first conc_second saturated                | done, one cycle
//  config    | cfg_wdata (peak_scale)                          | cfg_we
//
// Clear and append leave the block idle. A query walks the stored filaments in order:
// an invalid or out-of-range filament leaves after S_READ, S_SQ, S_SUM, S_W and S_CHK;
// an in-range one adds two divisions (16 and 64 steps) and the product and sum states.
// Reset clears the entry count and peak_scale; table contents stay undefined.
// The result receiver cannot stall; busy holds off new items during a query.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_puff_concentration_sum
    import gpcs_pkg::*;
#(
    parameter int MAX_FILAMENTS  = 1024,
    parameter int EXP_TABLE_BITS = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 command,
    input  wire logic signed [POS_W-1:0]    pos_x,
    input  wire logic signed [POS_W-1:0]    pos_y,
    input  wire logic signed [POS_W-1:0]    pos_z,
    input  wire logic [SPREAD_W-1:0]        spread,
    input  wire logic                       entry_valid,
    input  wire logic                       gas_group,
    output logic                            done,
    output logic [SUM_W-1:0]                conc_first,
    output logic [SUM_W-1:0]                conc_second,
    output logic                            saturated,
    input  wire logic                       cfg_we,
    input  wire logic [PEAK_W-1:0]          cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_FILAMENTS);
    localparam int CNT_W  = $clog2(MAX_FILAMENTS + 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_READ = 12'b000000000010,
        S_SQ   = 12'b000000000100,
        S_SUM  = 12'b000000001000,
        S_W    = 12'b000000010000,
        S_CHK  = 12'b000000100000,
        S_DIVR = 12'b000001000000,
        S_DIVT = 12'b000010000000,
        S_MULH = 12'b000100000000,
        S_MULL = 12'b001000000000,
        S_ACC  = 12'b010000000000,
        S_DONE = 12'b100000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [PEAK_W-1:0]  peak_reg;
    logic [SUM_W-1:0]   sum0_reg, sum0_next;
    logic [SUM_W-1:0]   sum1_reg, sum1_next;

    logic accept;
    assign accept = start && (state_reg == S_IDLE);

    // ---------------- table memory ----------------
    entry_t             wr_entry;
    entry_t             ent;
    logic [ENTRY_W-1:0] rd_word;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic               last_entry;
    logic               advance;

    assign wr_entry = '{grp: gas_group, vld: entry_valid, spread: spread,
                        z: pos_z, y: pos_y, x: pos_x};
    assign ram_we   = accept && (command == CMD_APPEND)
                      && (count_reg < CNT_W'(MAX_FILAMENTS));
    assign ent      = entry_t'(rd_word);

    gpcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FILAMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_word)
    );

    // ---------------- per-filament datapath ----------------
    logic signed [POS_W-1:0] qx_reg, qy_reg, qz_reg;
    logic signed [POS_W:0]   dx_reg, dy_reg, dz_reg;
    logic signed [2*POS_W+1:0] prod_x, prod_y, prod_z;
    logic [2*POS_W:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [2*SPREAD_W-1:0]   s2_reg;
    logic [2*POS_W+2:0]      d2_reg;
    logic [2*POS_W+7:0]      w_reg;
    logic [2*SPREAD_W-1:0]   phi_reg, plo_reg;
    logic [DEN_W-1:0]        s3;
    logic                    in_range;
    logic [15:0]             r_reg;
    logic [QUO_W-1:0]        t_reg;
    logic [E_W-1:0]          e_val;
    logic [62:0]             hp_reg;
    logic [62:0]             loe;
    logic [SUM_W:0]          v_sum;
    logic [SUM_W-1:0]        term_reg;
    logic                    grp_reg;
    logic [QUO_W-1:0]        div_quo;
    logic                    div_done;

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign prod_z = dz_reg * dz_reg;
    assign s3     = {phi_reg, {SPREAD_W{1'b0}}} + {{SPREAD_W{1'b0}}, plo_reg};
    assign in_range = ent.vld && (ent.spread != '0)
                      && (w_reg < {8'b0, s2_reg});
    assign loe    = t_reg[31:0] * 63'(e_val);
    assign v_sum  = {1'b0, hp_reg[45:0], 2'b0} + {16'b0, loe[62:30]};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
            qz_reg <= pos_z;
        end
        // coordinate differences
        if (state_reg == S_READ)
        begin
            dx_reg  <= {qx_reg[POS_W-1], qx_reg} - {ent.x[POS_W-1], ent.x};
            dy_reg  <= {qy_reg[POS_W-1], qy_reg} - {ent.y[POS_W-1], ent.y};
            dz_reg  <= {qz_reg[POS_W-1], qz_reg} - {ent.z[POS_W-1], ent.z};
            grp_reg <= ent.grp;
        end
        // squares
        if (state_reg == S_SQ)
        begin
            sqx_reg <= prod_x[2*POS_W:0];
            sqy_reg <= prod_y[2*POS_W:0];
            sqz_reg <= prod_z[2*POS_W:0];
            s2_reg  <= ent.spread * ent.spread;
        end
        if (state_reg == S_SUM)
        begin
            d2_reg <= (2*POS_W+3)'(sqx_reg) + (2*POS_W+3)'(sqy_reg)
                      + (2*POS_W+3)'(sqz_reg);
        end
        // w = 25 * d2, upper partial of sigma^3
        if (state_reg == S_W)
        begin
            w_reg   <= {d2_reg, 5'b0} - (2*POS_W+8)'({d2_reg, 3'b0})
                       + (2*POS_W+8)'(d2_reg);
            phi_reg <= s2_reg[2*SPREAD_W-1:SPREAD_W] * ent.spread;
        end
        if (state_reg == S_CHK)
        begin
            plo_reg <= s2_reg[SPREAD_W-1:0] * ent.spread;
        end
        if ((state_reg == S_DIVR) && div_done)
        begin
            r_reg <= div_quo[15:0];
        end
        if ((state_reg == S_DIVT) && div_done)
        begin
            t_reg <= div_quo;
        end
        if (state_reg == S_MULH)
        begin
            hp_reg <= t_reg[63:32] * 63'(e_val);
        end
        // saturated term
        if (state_reg == S_MULL)
        begin
            if (hp_reg >= (63'd1 << 46))
                term_reg <= SUM_MAX;
            else if (v_sum > {1'b0, SUM_MAX})
                term_reg <= SUM_MAX;
            else
                term_reg <= v_sum[SUM_W-1:0];
        end
    end

    // ---------------- shared divider ----------------
    div_ctl_t           div_ctl;
    logic [DEN_W-1:0]   div_rem_init;
    logic [QUO_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;

    always_comb
    begin
        div_ctl.start = 1'b0;
        div_ctl.iters = ITERS_R;
        div_rem_init  = DEN_W'(w_reg[2*SPREAD_W-1:0]);
        div_num       = '0;
        div_den       = DEN_W'(s2_reg);
        if ((state_reg == S_CHK) && in_range)
        begin
            div_ctl.start = 1'b1;
        end
        else if (state_reg == S_DIVR)
        begin
            div_ctl.start = div_done;
            div_ctl.iters = ITERS_T;
            div_rem_init  = '0;
            div_num       = {peak_reg, {(QUO_W-PEAK_W){1'b0}}};
            div_den       = s3;
        end
    end

    gpcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_init (div_rem_init),
        .num      (div_num),
        .den      (div_den),
        .quo      (div_quo),
        .done     (div_done)
    );

    gpcs_exp #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_exp (
        .clk   (clk),
        .ratio (r_reg),
        .e     (e_val)
    );

    // ---------------- sequencer ----------------
    logic [SUM_W:0] acc0, acc1;
    assign acc0 = {1'b0, sum0_reg} + {1'b0, term_reg};
    assign acc1 = {1'b0, sum1_reg} + {1'b0, term_reg};
    assign last_entry = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign advance = ((state_reg == S_CHK) && !in_range) || (state_reg == S_ACC);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        sum0_next  = sum0_reg;
        sum1_next  = sum1_reg;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg + 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (ram_we)
                                count_next = count_reg + 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            sum0_next = '0;
                            sum1_next = '0;
                            idx_next  = '0;
                            if (count_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: state_next = S_SQ;
            S_SQ:   state_next = S_SUM;
            S_SUM:  state_next = S_W;
            S_W:    state_next = S_CHK;
            S_CHK:
            begin
                if (in_range)
                    state_next = S_DIVR;
            end
            S_DIVR:
            begin
                if (div_done)
                    state_next = S_DIVT;
            end
            S_DIVT:
            begin
                if (div_done)
                    state_next = S_MULH;
            end
            S_MULH: state_next = S_MULL;
            S_MULL: state_next = S_ACC;
            S_ACC:
            begin
                if (grp_reg)
                    sum1_next = (acc1 > {1'b0, SUM_MAX}) ? SUM_MAX : acc1[SUM_W-1:0];
                else
                    sum0_next = (acc0 > {1'b0, SUM_MAX}) ? SUM_MAX : acc0[SUM_W-1:0];
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        // move to the next filament or finish
        if (advance)
        begin
            if (last_entry)
            begin
                state_next = S_DONE;
            end
            else
            begin
                ram_re     = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = S_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            peak_reg  <= '0;
            sum0_reg  <= '0;
            sum1_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            sum0_reg  <= sum0_next;
            sum1_reg  <= sum1_next;
            if (cfg_we)
                peak_reg <= cfg_wdata;
        end
    end

    // outputs
    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_DONE);
    assign conc_first  = sum0_reg;
    assign conc_second = sum1_reg;
    assign saturated   = (sum0_reg == SUM_MAX) || (sum1_reg == SUM_MAX);

endmodule

`default_nettype wire

/* hdl/gpcs_chk.sv */
// Port-level checker for the concentration block, bound to the top level.
// Depends on gpcs_pkg and gaussian_puff_concentration_sum.
`timescale 1ns / 1ps
`default_nettype none

module gpcs_chk
    import gpcs_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic [1:0]       command,
    input wire logic             done,
    input wire logic [SUM_W-1:0] conc_first,
    input wire logic [SUM_W-1:0] conc_second,
    input wire logic             saturated
);

    // a result only shows while the block is occupied
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // the block is free again right after a result
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result");

    // clear, append and unknown commands leave the block idle and raise no result
    a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != CMD_QUERY)) |=> (!busy && !done))
        else $error("short command kept block busy");

    // saturation flag agrees with the sums
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (saturated == ((conc_first == SUM_MAX) || (conc_second == SUM_MAX))))
        else $error("saturated flag mismatch");

endmodule

bind gaussian_puff_concentration_sum gpcs_chk u_gpcs_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .done        (done),
    .conc_first  (conc_first),
    .conc_second (conc_second),
    .saturated   (saturated)
);

`default_nettype wire

/* dv/tb_gaussian_puff_concentration_sum.sv */
// Self-checking testbench for gaussian_puff_concentration_sum: directed table, then random
// filament tables and queries, checked against an in-bench concentration predictor.
// Depends on gpcs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_gaussian_puff_concentration_sum;
    import gpcs_pkg::*;

    localparam int TBL_DEPTH = 64;
    localparam int EXP_BITS  = 8;
    localparam int N_COARSE  = 13;
    localparam longint WATCHDOG_CYCLES = 4000000;
    localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};
    localparam logic signed [POS_W-1:0] POS_HI = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_LO = -24'sh800000;
    localparam logic [1:0] CMD_BAD = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] first;
        logic [SUM_W-1:0] second;
        logic             sat;
    } conc_t;

    // one row of the directed table
    typedef struct {
        logic                    cfg_en;
        logic [PEAK_W-1:0]       cfg_val;
        logic [1:0]              cmd;
        logic signed [POS_W-1:0] x, y, z;
        logic [SPREAD_W-1:0]     s;
        logic                    v, g;
        logic                    typed;
        conc_t                   want;
    } row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] command;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [SPREAD_W-1:0] spread;
    logic entry_valid, gas_group;
    logic done;
    logic [SUM_W-1:0] conc_first, conc_second;
    logic saturated;
    logic cfg_we;
    logic [PEAK_W-1:0] cfg_wdata;

    gaussian_puff_concentration_sum #(
        .MAX_FILAMENTS (TBL_DEPTH),
        .EXP_TABLE_BITS (EXP_BITS)
    ) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .spread(spread),
        .entry_valid(entry_valid), .gas_group(gas_group), .done(done),
        .conc_first(conc_first), .conc_second(conc_second), .saturated(saturated),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    logic signed [POS_W-1:0] fil_x[TBL_DEPTH], fil_y[TBL_DEPTH], fil_z[TBL_DEPTH];
    logic [SPREAD_W-1:0]     fil_s[TBL_DEPTH];
    logic                    fil_v[TBL_DEPTH], fil_g[TBL_DEPTH];
    int                      fil_count;
    logic [PEAK_W-1:0]       peak_reg;
    logic [63:0]             fine_lut[1 << EXP_BITS];
    logic [63:0]             coarse_lut[N_COARSE];

    conc_t pending_conc[$];
    int    mismatches;
    longint cycle_count;
    int    burst_left;
    int    items_sent;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // exp(-x), x in Q30 up to 1.0, alternating series cut after nterm terms
    function automatic logic [63:0] exp_neg(input logic [63:0] x, input int nterm);
        longint      acc;
        logic [63:0] t;
        acc = longint'(64'd1 << 30);
        t = 64'd1 << 30;
        for (int k = 1; k <= nterm; k++)
        begin
            t = ((t * x) >> 30) / 64'(k);
            acc = (k % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    function automatic logic [63:0] sq_dist(input logic signed [POS_W-1:0] a,
                                            input logic signed [POS_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return 64'(d) * 64'(d);
    endfunction

    // one filament's contribution, saturated
    function automatic logic [63:0] puff_term(input logic [63:0] d2, input logic [63:0] s);
        logic [63:0] s2, w, r, u, n, f, e, t, hp, v;
        s2 = s * s;
        w = 25 * d2;
        if (s == 0 || w >= s2)
            return 64'd0;
        r = (w << 16) / s2;
        u = ((25 * r) << EXP_BITS) >> 17;
        n = u >> EXP_BITS;
        if (n >= N_COARSE)
            n = N_COARSE - 1;
        f = u & ((1 << EXP_BITS) - 1);
        e = (coarse_lut[n] * fine_lut[f] + (64'd1 << 29)) >> 30;
        t = (((64'(peak_reg) << 24) / s) / s) / s;
        hp = (t >> 32) * e;
        if (hp >= (64'd1 << 46))
            return 64'(SUM_MAX);
        v = (hp << 2) + (((t & 64'hFFFF_FFFF) * e) >> 30);
        return (v > 64'(SUM_MAX)) ? 64'(SUM_MAX) : v;
    endfunction

    function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > 64'(SUM_MAX)) ? 64'(SUM_MAX) : s;
    endfunction

    // update the filament table; returns 1 with the concentrations for a query
    function automatic logic apply_command(input logic [1:0] cmd,
        input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
        input logic signed [POS_W-1:0] z, input logic [SPREAD_W-1:0] s,
        input logic v, input logic g, output conc_t res);
        logic [63:0] acc0, acc1, d2, c;
        acc0 = 0;
        acc1 = 0;
        res = '0;
        if (cmd == CMD_CLEAR)
            fil_count = 0;
        else if (cmd == CMD_APPEND)
        begin
            if (fil_count < TBL_DEPTH)
            begin
                fil_x[fil_count] = x;
                fil_y[fil_count] = y;
                fil_z[fil_count] = z;
                fil_s[fil_count] = s;
                fil_v[fil_count] = v;
                fil_g[fil_count] = g;
                fil_count++;
            end
        end
        else if (cmd == CMD_QUERY)
        begin
            for (int i = 0; i < fil_count; i++)
            begin
                if (!fil_v[i])
                    continue;
                d2 = sq_dist(x, fil_x[i]) + sq_dist(y, fil_y[i]) + sq_dist(z, fil_z[i]);
                c = puff_term(d2, 64'(fil_s[i]));
                if (fil_g[i])
                    acc1 = add_clip(acc1, c);
                else
                    acc0 = add_clip(acc0, c);
            end
            res.first = acc0[SUM_W-1:0];
            res.second = acc1[SUM_W-1:0];
            res.sat = (acc0 == 64'(SUM_MAX)) || (acc1 == 64'(SUM_MAX));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // send one item, record its expected result, then maybe idle
    task automatic send_item(input logic [1:0] cmd, input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y, input logic signed [POS_W-1:0] z,
        input logic [SPREAD_W-1:0] s, input logic v, input logic g,
        input logic typed, input conc_t want);
        conc_t res;
        conc_t exp_item;
        int    gap;
        start <= 1'b1;
        command <= cmd;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        spread <= s;
        entry_valid <= v;
        gas_group <= g;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (apply_command(cmd, x, y, z, s, v, g, res))
        begin
            exp_item = typed ? want : res;
            pending_conc = {pending_conc, exp_item};
        end
        // bursty sender
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    task automatic send_rand(input logic [1:0] cmd, input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y, input logic signed [POS_W-1:0] z,
        input logic [SPREAD_W-1:0] s, input logic v, input logic g);
        send_item(cmd, x, y, z, s, v, g, 1'b0, '0);
    endtask

    // wait for all results and for the block to settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_conc.size() != 0 || busy)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_peak(input logic [PEAK_W-1:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        peak_reg = val;
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    function automatic logic signed [POS_W-1:0] near_pos(input logic signed [POS_W-1:0] c,
                                                        input int span);
        int off;
        off = int'($urandom_range(0, 2 * span)) - span;
        return POS_W'(int'(c) + off);
    endfunction

    function automatic logic [SPREAD_W-1:0] rand_spread();
        int w;
        logic [SPREAD_W-1:0] s;
        w = $urandom_range(1, SPREAD_W);
        s = SPREAD_W'($urandom) & SPREAD_W'((32'd1 << w) - 1);
        return (s == 0) ? SPREAD_W'(1) : s;
    endfunction

    function automatic logic [PEAK_W-1:0] rand_peak();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return PEAK_MAX;
            2: return PEAK_W'({$urandom, $urandom});
            default: return PEAK_W'($urandom_range(1, 32'h00FF_FFFF));
        endcase
    endfunction

    // result checker: the block cannot be stalled
    always @(posedge clk)
    begin
        conc_t got;
        conc_t exp_c;
        if (rst_n && done)
        begin
            got = '{conc_first, conc_second, saturated};
            if (pending_conc.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %h %h %b", conc_first, conc_second,
                             saturated);
            end
            else
            begin
                exp_c = pending_conc.pop_front();
                if (got.first !== exp_c.first || got.second !== exp_c.second
                    || got.sat !== exp_c.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %b got %h %h %b", exp_c.first,
                                 exp_c.second, exp_c.sat, got.first, got.second, got.sat);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > WATCHDOG_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        conc_t zero_c;
        conc_t nop;
        logic signed [POS_W-1:0] cx, cy, cz;
        logic [SPREAD_W-1:0] s;
        int nfil, nq, span;

        zero_c = '0;
        nop = '0;
        mismatches = 0;
        cycle_count = 0;
        burst_left = 0;
        items_sent = 0;
        fil_count = 0;
        peak_reg = '0;
        for (int i = 0; i < (1 << EXP_BITS); i++)
            fine_lut[i] = exp_neg(64'(i) << (30 - EXP_BITS), 16);
        coarse_lut[0] = 64'd1 << 30;
        for (int i = 1; i < N_COARSE; i++)
            coarse_lut[i] = (coarse_lut[i-1] * exp_neg(64'd1 << 30, 20) + (64'd1 << 29)) >> 30;

        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_CLEAR;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        spread = '0;
        entry_valid = 1'b0;
        gas_group = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        rows = '{
            '{0, 0, CMD_QUERY, 0, 0, 0, 0, 0, 0, 1, '0},
            '{0, 0, CMD_BAD, POS_HI, POS_LO, 0, 5, 1, 1, 0, '0},
            '{0, 0, CMD_APPEND, POS_HI, POS_HI, POS_HI, 24'hFFFFFF, 1, 1, 0, '0},
            '{0, 0, CMD_APPEND, POS_LO, POS_LO, POS_LO, 24'd1, 1, 0, 0, '0},
            '{0, 0, CMD_APPEND, 0, 0, 0, 24'd0, 1, 0, 0, '0},
            '{0, 0, CMD_APPEND, 0, 0, 0, 24'd256, 0, 1, 0, '0},
            '{0, 0, CMD_QUERY, POS_HI, POS_HI, POS_HI, 0, 0, 0, 1, '0},
            '{1, PEAK_MAX, CMD_QUERY, POS_HI, POS_HI, POS_HI, 0, 0, 0, 0, '0},
            '{0, 0, CMD_QUERY, POS_LO, POS_LO, POS_LO, 0, 0, 0, 0, '0},
            '{0, 0, CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, '0},
            '{0, 0, CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, '0},
            '{0, 0, CMD_APPEND, 0, 0, 0, 24'd1, 1, 0, 0, '0},
            '{0, 0, CMD_QUERY, 0, 0, 0, 0, 0, 0, 1, '{SUM_MAX, 48'd0, 1'b1}},
            '{0, 0, CMD_APPEND, 0, 0, 0, 24'd1, 1, 1, 0, '0},
            '{0, 0, CMD_QUERY, 0, 0, 0, 0, 0, 0, 1, '{SUM_MAX, SUM_MAX, 1'b1}},
            '{0, 0, CMD_QUERY, POS_HI, 0, 0, 0, 0, 0, 1, '0},
            '{1, 40'h1_0000, CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, '0},
            '{0, 0, CMD_APPEND, 100, -100, 7, 24'd2560, 1, 0, 0, '0},
            '{0, 0, CMD_APPEND, 90, -90, 0, 24'd25600, 1, 1, 0, '0},
            '{0, 0, CMD_QUERY, 100, -100, 7, 0, 0, 0, 0, '0},
            '{0, 0, CMD_QUERY, 150, -60, 20, 0, 0, 0, 0, '0},
            '{0, 0, CMD_QUERY, POS_LO, POS_HI, 0, 0, 0, 0, 1, '0},
            '{0, 0, CMD_BAD, 0, 0, 0, 0, 0, 0, 0, '0}
        };
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.cfg_en)
                write_peak(r.cfg_val);
            send_item(r.cmd, r.x, r.y, r.z, r.s, r.v, r.g, r.typed, r.want);
        end

        // full table: appends past the end are dropped
        write_peak(rand_peak());
        send_rand(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < TBL_DEPTH + 6; i++)
            send_rand(CMD_APPEND, rand_pos(), rand_pos(), rand_pos(),
                      SPREAD_W'($urandom_range(1, 4095)), $urandom_range(0, 1),
                      $urandom_range(0, 1));
        send_rand(CMD_QUERY, rand_pos(), rand_pos(), rand_pos(), 0, 0, 0);
        send_rand(CMD_QUERY, fil_x[7], fil_y[7], fil_z[7], 0, 0, 0);
        write_peak(0);

        // random phases: small clustered tables with queries, mostly around the cluster, and bad commands
        while (items_sent < 570)
        begin
            if ($urandom_range(0, 3) == 0)
                write_peak(rand_peak());
            else if ($urandom_range(0, 5) == 0)
                drain();
            send_rand(CMD_CLEAR, rand_pos(), rand_pos(), rand_pos(), rand_spread(),
                      $urandom_range(0, 1), $urandom_range(0, 1));
            cx = rand_pos();
            cy = rand_pos();
            cz = rand_pos();
            nfil = $urandom_range(0, 10);
            for (int i = 0; i < nfil; i++)
            begin
                s = rand_spread();
                span = int'(s) / 12;
                send_rand(CMD_APPEND, near_pos(cx, span), near_pos(cy, span),
                          near_pos(cz, span), s, $urandom_range(0, 7) != 0,
                          $urandom_range(0, 1));
            end
            nq = $urandom_range(1, 4);
            for (int q = 0; q < nq; q++)
            begin
                span = (nfil > 0) ? int'(fil_s[$urandom_range(0, nfil - 1)]) / 10 : 8;
                case ($urandom_range(0, 7))
                    0: send_rand(CMD_QUERY, rand_pos(), rand_pos(), rand_pos(), rand_spread(),
                                 1, 1);
                    1: send_rand(CMD_BAD, rand_pos(), rand_pos(), rand_pos(), rand_spread(),
                                 $urandom_range(0, 1), $urandom_range(0, 1));
                    2: send_rand(CMD_QUERY, near_pos(cx, 3 * span), near_pos(cy, 3 * span),
                                 near_pos(cz, 3 * span), 0, 0, 0);
                    default: send_rand(CMD_QUERY, near_pos(cx, span), near_pos(cy, span),
                                       near_pos(cz, span), 0, 0, 0);
                endcase
            end
        end

        // let everything come out
        drain();
        repeat (20)
            @(posedge clk);
        if (mismatches == 0 && pending_conc.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
